### rtl/matrix_invert_4x4_defines.svh
// Assertion macros shared by the matrix inverter RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MATRIX_INVERT_4X4_DEFINES_SVH
`define MATRIX_INVERT_4X4_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MI4_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrix inverter assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MI4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrix inverter assertion failed");

`endif

### rtl/mi4_pkg.sv
// Types, widths and the step decoder of the 4x4 matrix inverter.
// Depends on nothing; used by matrix_invert_4x4.
`default_nettype none
package mi4_pkg;

  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned PROD_W  = 65;
  localparam int unsigned T_W     = 66;
  localparam int unsigned COF_W   = 98;
  localparam int unsigned WIDE_W  = 128;
  localparam int unsigned ACC_W   = 130;
  localparam int unsigned QUO_W   = 34;

  localparam logic [3:0] LAST_OP  = 4'd8;
  localparam logic [3:0] LAST_IDX = 4'd15;

  typedef struct packed {
    logic       use_t;
    logic       sub;
    logic       to_t;
    logic       clear;
    logic [3:0] w_k;
    logic [3:0] e_k;
  } mul_op_t;

  // One multiply-accumulate step of the 3x3 determinant by first-row expansion.
  function automatic mul_op_t op_decode(logic [3:0] op);
    mul_op_t r;
    unique case (op)
      4'd0:    r = '{1'b0, 1'b0, 1'b1, 1'b1, 4'd4, 4'd8};
      4'd1:    r = '{1'b0, 1'b1, 1'b1, 1'b0, 4'd5, 4'd7};
      4'd2:    r = '{1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 4'd0};
      4'd3:    r = '{1'b0, 1'b0, 1'b1, 1'b1, 4'd3, 4'd8};
      4'd4:    r = '{1'b0, 1'b1, 1'b1, 1'b0, 4'd5, 4'd6};
      4'd5:    r = '{1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 4'd1};
      4'd6:    r = '{1'b0, 1'b0, 1'b1, 1'b1, 4'd3, 4'd7};
      4'd7:    r = '{1'b0, 1'b1, 1'b1, 1'b0, 4'd4, 4'd6};
      4'd8:    r = '{1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 4'd2};
      default: r = '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0};
    endcase
    return r;
  endfunction

  // Maps minor position k (row-major in the 3x3 minor) to the 4x4 store index.
  function automatic logic [3:0] minor_pos(logic [3:0] k, logic [1:0] p, logic [1:0] q);
    logic [1:0] mr;
    logic [1:0] mc;
    logic [1:0] r;
    logic [1:0] c;
    unique case (k)
      4'd0:    begin mr = 2'd0; mc = 2'd0; end
      4'd1:    begin mr = 2'd0; mc = 2'd1; end
      4'd2:    begin mr = 2'd0; mc = 2'd2; end
      4'd3:    begin mr = 2'd1; mc = 2'd0; end
      4'd4:    begin mr = 2'd1; mc = 2'd1; end
      4'd5:    begin mr = 2'd1; mc = 2'd2; end
      4'd6:    begin mr = 2'd2; mc = 2'd0; end
      4'd7:    begin mr = 2'd2; mc = 2'd1; end
      4'd8:    begin mr = 2'd2; mc = 2'd2; end
      default: begin mr = 2'd0; mc = 2'd0; end
    endcase
    r = (mr >= p) ? mr + 2'd1 : mr;
    c = (mc >= q) ? mc + 2'd1 : mc;
    return {r, c};
  endfunction

endpackage
`default_nettype wire

### rtl/matrix_invert_4x4.sv
// 4x4 matrix inverse by adjugate in signed fixed point, with one shared multiplier.
// Depends on mi4_pkg and matrix_invert_4x4_defines.svh.
//
//   channel  | signals                                          | direction
//   input    | in_valid_i, in_ready_o, element_i                | in
//   output   | out_valid_o, out_ready_i, result_element_o,      | out
//            | elem_index_o, singular_o, last_o                 |
//
// Fifteen items load in one cycle each; the sixteenth starts the solve.
// The 33x32 multiplier runs 9 steps of 1 or 4 chunks per cofactor; after all cofactors
// the determinant is accumulated, then checked for zero.
// Each result goes through select, divider setup, a range check, 34 quotient bits,
// the output load and the handshake; an overflowing quotient skips the bits.
// A singular matrix is echoed element by element, each awaiting its handshake. Reset
// clears all control state. A stalled output holds the solve; no item is taken until
// the last result leaves.
`default_nettype none
`include "matrix_invert_4x4_defines.svh"

module matrix_invert_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [mi4_pkg::ELEM_W-1:0]    element_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [mi4_pkg::ELEM_W-1:0]         result_element_o,
  output logic [3:0]                                elem_index_o,
  output logic                                      singular_o,
  output logic                                      last_o
);
  import mi4_pkg::*;

  localparam int unsigned NUM_W = COF_W + 2 * FRAC_BITS + 1;
  localparam int unsigned DIV_W = (NUM_W > ACC_W + QUO_W) ? NUM_W : ACC_W + QUO_W;

  typedef enum logic [2:0] {
    ST_LOAD, ST_COF, ST_DET, ST_CHK, ST_SEL, ST_DINIT, ST_DIV, ST_EMIT
  } state_e;

  state_e                   state_q;
  logic signed [ELEM_W-1:0] m_q [16];
  logic [COF_W-1:0]         cof_q [16];
  logic [3:0]               load_cnt_q;
  logic [3:0]               cidx_q;
  logic [3:0]               op_q;
  logic [1:0]               ch_q;
  logic [T_W-1:0]           t_q;
  logic [ACC_W-1:0]         acc_q;
  logic [3:0]               k_q;
  logic                     sing_q;
  logic [DIV_W-1:0]         rem_q;
  logic [DIV_W-1:0]         dsh_q;
  logic [QUO_W-1:0]         quo_q;
  logic [5:0]               it_q;
  logic                     big_q;
  logic                     neg_q;
  logic                     fin_q;

  mul_op_t                  op_d;
  logic                     det_mode;
  logic                     four_ch;
  logic                     last_ch;
  logic [WIDE_W-1:0]        wide_w;
  logic [CHUNK_W-1:0]       chunk;
  logic signed [ELEM_W-1:0] e_val;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         addend;
  logic [ACC_W-1:0]         base;
  logic [ACC_W-1:0]         sum;
  logic [COF_W-1:0]         cof_new;
  logic [COF_W-1:0]         c_sel;
  logic [COF_W-1:0]         c_abs;
  logic [ACC_W-1:0]         d_abs;
  logic                     ge;
  logic [QUO_W-1:0]         rnd;
  logic [ELEM_W-1:0]        res;

  always_comb begin
    op_d     = op_decode(op_q);
    det_mode = (state_q == ST_DET);
    four_ch  = det_mode || op_d.use_t;
    last_ch  = four_ch ? (ch_q == 2'd3) : 1'b1;
    if (det_mode) begin
      wide_w = {{(WIDE_W-COF_W){cof_q[cidx_q][COF_W-1]}}, cof_q[cidx_q]};
      e_val  = m_q[{2'b00, cidx_q[1:0]}];
    end else if (op_d.use_t) begin
      wide_w = {{(WIDE_W-T_W){t_q[T_W-1]}}, t_q};
      e_val  = m_q[minor_pos(op_d.e_k, cidx_q[3:2], cidx_q[1:0])];
    end else begin
      wide_w = {{(WIDE_W-ELEM_W){m_q[minor_pos(op_d.w_k, cidx_q[3:2], cidx_q[1:0])]
                 [ELEM_W-1]}}, m_q[minor_pos(op_d.w_k, cidx_q[3:2], cidx_q[1:0])]};
      e_val  = m_q[minor_pos(op_d.e_k, cidx_q[3:2], cidx_q[1:0])];
    end
    chunk  = wide_w[ch_q*CHUNK_W +: CHUNK_W];
    prod   = $signed({last_ch & chunk[CHUNK_W-1], chunk}) * e_val;
    addend = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} << (CHUNK_W * ch_q);
    if (!det_mode && op_d.to_t) begin
      base = (op_d.clear && ch_q == 2'd0) ? '0 : {{(ACC_W-T_W){t_q[T_W-1]}}, t_q};
    end else begin
      base = ((det_mode ? (cidx_q == 4'd0) : op_d.clear) && ch_q == 2'd0) ? '0 : acc_q;
    end
    sum     = (!det_mode && op_d.sub) ? base - addend : base + addend;
    cof_new = (cidx_q[2] ^ cidx_q[0]) ? COF_W'(-sum[COF_W-1:0]) : sum[COF_W-1:0];

    c_sel = cof_q[{k_q[1:0], k_q[3:2]}];
    c_abs = c_sel[COF_W-1] ? COF_W'(-c_sel) : c_sel;
    d_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
    ge    = (rem_q >= dsh_q);

    rnd = QUO_W'(({1'b0, quo_q} + {{QUO_W{1'b0}}, 1'b1}) >> 1);
    if (!neg_q) begin
      res = (big_q || rnd > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rnd[ELEM_W-1:0];
    end else begin
      res = (big_q || rnd > QUO_W'(32'h8000_0000)) ? 32'h8000_0000
                                                      : ELEM_W'(-rnd[ELEM_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && in_valid_i) begin
      m_q[load_cnt_q] <= element_i;
    end
    if (state_q == ST_COF && last_ch && op_q == LAST_OP) begin
      cof_q[cidx_q] <= cof_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_LOAD;
      load_cnt_q       <= '0;
      cidx_q           <= '0;
      op_q             <= '0;
      ch_q             <= '0;
      t_q              <= '0;
      acc_q            <= '0;
      k_q              <= '0;
      sing_q           <= 1'b0;
      rem_q            <= '0;
      dsh_q            <= '0;
      quo_q            <= '0;
      it_q             <= '0;
      big_q            <= 1'b0;
      neg_q            <= 1'b0;
      fin_q            <= 1'b0;
      out_valid_o      <= 1'b0;
      result_element_o <= '0;
      elem_index_o     <= '0;
      singular_o       <= 1'b0;
      last_o           <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            load_cnt_q <= load_cnt_q + 4'd1;
            if (load_cnt_q == LAST_IDX) begin
              state_q <= ST_COF;
              cidx_q  <= '0;
              op_q    <= '0;
              ch_q    <= '0;
            end
          end
        end
        ST_COF: begin
          if (op_d.to_t) begin
            t_q <= sum[T_W-1:0];
          end else begin
            acc_q <= sum;
          end
          if (last_ch) begin
            ch_q <= '0;
            if (op_q == LAST_OP) begin
              op_q   <= '0;
              cidx_q <= cidx_q + 4'd1;
              if (cidx_q == LAST_IDX) begin
                state_q <= ST_DET;
              end
            end else begin
              op_q <= op_q + 4'd1;
            end
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        ST_DET: begin
          acc_q <= sum;
          ch_q  <= ch_q + 2'd1;
          if (last_ch) begin
            cidx_q <= cidx_q + 4'd1;
            if (cidx_q == 4'd3) begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          sing_q  <= (acc_q == '0);
          k_q     <= '0;
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          if (sing_q) begin
            out_valid_o      <= 1'b1;
            result_element_o <= m_q[k_q];
            elem_index_o     <= k_q;
            singular_o       <= 1'b1;
            last_o           <= (k_q == LAST_IDX);
            state_q          <= ST_EMIT;
          end else begin
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          rem_q   <= DIV_W'(c_abs) << (2 * FRAC_BITS + 1);
          dsh_q   <= DIV_W'(d_abs) << QUO_W;
          quo_q   <= '0;
          it_q    <= 6'(QUO_W);
          big_q   <= 1'b0;
          fin_q   <= 1'b0;
          neg_q   <= c_sel[COF_W-1] ^ acc_q[ACC_W-1];
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (fin_q) begin
            out_valid_o      <= 1'b1;
            result_element_o <= res;
            elem_index_o     <= k_q;
            singular_o       <= 1'b0;
            last_o           <= (k_q == LAST_IDX);
            state_q          <= ST_EMIT;
          end else if (it_q == 6'(QUO_W)) begin
            big_q <= ge;
            fin_q <= ge;
            dsh_q <= dsh_q >> 1;
            it_q  <= it_q - 6'd1;
          end else begin
            if (ge) begin
              rem_q <= rem_q - dsh_q;
            end
            quo_q <= {quo_q[QUO_W-2:0], ge};
            dsh_q <= dsh_q >> 1;
            fin_q <= (it_q == 6'd0);
            it_q  <= it_q - 6'd1;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (k_q == LAST_IDX) begin
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= ST_SEL;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);

  `MI4_ASSERT_SAME(a_no_load_while_out, in_ready_o, !out_valid_o)
  `MI4_ASSERT_SAME(a_last_index, out_valid_o && last_o, elem_index_o == LAST_IDX)
  `MI4_ASSERT_NEXT(a_reload_after_last, out_valid_o && out_ready_i && last_o, in_ready_o)
  `MI4_ASSERT_SAME(a_singular_zero_det, out_valid_o && singular_o, acc_q == '0)

endmodule
`default_nettype wire
